### rtl/jadd_pkg.sv
// Package for the joystick axis deadzone and debounce unit.
// Holds field widths, register indexes and reset values; depends on nothing.
package jadd_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int CENTER_W   = 12;
  localparam int DEADZONE_W = 12;
  localparam int AXIS_W     = 15;
  localparam int DEBOUNCE_W = 8;
  localparam int OUT_W      = 16;
  localparam int CFG_DATA_W = 15;
  localparam int CFG_ADDR_W = 3;

  localparam int ADC_WIDTH_DEFAULT = 12;

  localparam int S_TDATA_W = 32;
  localparam int S_TUSER_W = 1;
  localparam int M_TDATA_W = 40;

  localparam logic [CFG_ADDR_W-1:0] REG_CENTER_X       = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CENTER_Y       = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DEADZONE       = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_AXIS_MAX       = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE_COUNT = 3'd4;

  localparam logic [CENTER_W-1:0]   CENTER_RESET   = 12'd2048;
  localparam logic [DEADZONE_W-1:0] DEADZONE_RESET = 12'd200;
  localparam logic [AXIS_W-1:0]     AXIS_MAX_RESET = 15'd1000;
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 8'd2;

endpackage

### rtl/joystick_axis_deadzone_debounce_unit.sv
// Top level of the joystick axis deadzone and debounce unit: offset, deadzone,
// clamp and bit-serial rescale of both axes, plus the button debouncer.
// Depends on jadd_pkg.
//
// Channel  | Direction | Contents
// s_axis   | in        | tdata: sample_x, sample_y, button_pin; tuser: sample_ok
// m_axis   | out       | tdata: x_out, y_out, btn_held, btn_rise
// cfg      | in        | write enable, register index, write data
//
// Each transaction passes ST_PREP, ST_MUL and ST_DIV for the x axis, again for
// the y axis, then ST_OUT: each axis gets offset and clamp, a multiply and the
// restoring divider, which yields one quotient bit per cycle. The input is
// accepted again once the result has entered the output register; a result
// still waiting there holds the next result in ST_OUT until taken. Reset clears all
// control state and loads the register defaults.
module joystick_axis_deadzone_debounce_unit #(
  parameter int ADC_WIDTH = jadd_pkg::ADC_WIDTH_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // sample_x [11:0], sample_y [23:12], button_pin [24], zero padding
  input  logic [jadd_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // sample_ok [0]
  input  logic [jadd_pkg::S_TUSER_W-1:0]  s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // x_out [15:0], y_out [31:16], btn_held [32], btn_rise [33], zero padding
  output logic [jadd_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  input  logic                            cfg_we_i,
  input  logic [jadd_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [jadd_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int SW_ = jadd_pkg::SAMPLE_W;
  localparam int AW_ = jadd_pkg::AXIS_W;
  localparam int OW_ = jadd_pkg::OUT_W;
  localparam int DW_ = jadd_pkg::DEBOUNCE_W;
  localparam int FullW = (ADC_WIDTH > SW_) ? ADC_WIDTH : SW_;
  localparam int VW = FullW + 3;
  localparam int ProdW = SW_ + AW_;
  localparam int CntW = $clog2(AW_);
  localparam logic [SW_-1:0] AdcMask =
    (ADC_WIDTH >= SW_) ? {SW_{1'b1}} : SW_'((2 ** ADC_WIDTH) - 1);
  localparam logic signed [VW-1:0] FullScale = VW'((2 ** ADC_WIDTH) - 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PREP = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [jadd_pkg::CENTER_W-1:0]   center_x_q, center_y_q;
  logic [jadd_pkg::DEADZONE_W-1:0] deadzone_q;
  logic [AW_-1:0]                  axis_max_q;
  logic [DW_-1:0]                  debounce_q;

  logic                            last_pin_q, stable_q;
  logic [DW_-1:0]                  match_q;

  logic [SW_-1:0] samp_x_q, samp_y_q;
  logic           ok_q, down_q, pressed_q, axis_q;
  logic [SW_-1:0] mag_q;
  logic [FullW-1:0] div_q, rem_q;
  logic [AW_-1:0] quo_q;
  logic           neg_q;
  logic [CntW-1:0] cnt_q;
  logic [OW_-1:0] x_res_q, y_res_q;

  logic                out_valid_q;
  logic [jadd_pkg::M_TDATA_W-1:0] out_data_q;

  logic accept, load_out;
  logic pressed_raw;
  logic [DW_-1:0] match_d;
  logic last_pin_d, stable_d;

  logic [SW_-1:0] raw_sel, center_sel;
  logic signed [VW-1:0] value, dz, span, mag, mag_c;
  logic zero_axis;
  logic [ProdW-1:0] prod;
  logic [FullW:0] trial;
  logic ge;
  logic [FullW:0] diff;
  logic [OW_-1:0] mag16, res;

  assign s_axis_tready = state_q == ST_IDLE;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign load_out = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = out_data_q;

  // Debounce update for the transaction being accepted.
  assign pressed_raw = ~s_axis_tdata[2*SW_];
  always_comb begin
    if (pressed_raw == last_pin_q) begin
      last_pin_d = last_pin_q;
      match_d = (match_q < debounce_q) ? match_q + 1'b1 : match_q;
    end else begin
      last_pin_d = pressed_raw;
      match_d = DW_'(1);
    end
    stable_d = (match_d >= debounce_q) ? last_pin_d : stable_q;
  end

  // Offset, deadzone and clamp of the selected axis.
  always_comb begin
    raw_sel = axis_q ? samp_y_q : samp_x_q;
    center_sel = axis_q ? center_y_q : center_x_q;
    dz = VW'(deadzone_q);
    value = VW'(raw_sel & AdcMask) - VW'(center_sel);
    if (value > 0) begin
      span = FullScale - VW'(center_sel) - dz;
      mag = value - dz;
    end else begin
      span = VW'(center_sel) - dz;
      mag = -value - dz;
    end
    mag_c = (mag > span) ? span : mag;
    zero_axis = !ok_q || ((value > -dz) && (value < dz)) || (span <= 0);
  end

  assign prod = ProdW'(mag_q) * ProdW'(axis_max_q);

  always_comb begin
    trial = {rem_q, quo_q[AW_-1]};
    diff = trial - {1'b0, div_q};
    ge = trial >= {1'b0, div_q};
    mag16 = {1'b0, quo_q[AW_-2:0], ge};
    res = neg_q ? OW_'(-mag16) : mag16;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: state_d = ST_MUL;
      ST_MUL:  state_d = ST_DIV;
      ST_DIV: begin
        if (cnt_q == '0) begin
          state_d = axis_q ? ST_OUT : ST_PREP;
        end
      end
      ST_OUT: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      center_x_q <= jadd_pkg::CENTER_RESET;
      center_y_q <= jadd_pkg::CENTER_RESET;
      deadzone_q <= jadd_pkg::DEADZONE_RESET;
      axis_max_q <= jadd_pkg::AXIS_MAX_RESET;
      debounce_q <= jadd_pkg::DEBOUNCE_RESET;
      last_pin_q <= 1'b0;
      stable_q <= 1'b0;
      match_q <= '0;
      axis_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          jadd_pkg::REG_CENTER_X:       center_x_q <= cfg_data_i[jadd_pkg::CENTER_W-1:0];
          jadd_pkg::REG_CENTER_Y:       center_y_q <= cfg_data_i[jadd_pkg::CENTER_W-1:0];
          jadd_pkg::REG_DEADZONE:       deadzone_q <= cfg_data_i[jadd_pkg::DEADZONE_W-1:0];
          jadd_pkg::REG_AXIS_MAX:       axis_max_q <= cfg_data_i[AW_-1:0];
          jadd_pkg::REG_DEBOUNCE_COUNT: debounce_q <= cfg_data_i[DW_-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        last_pin_q <= last_pin_d;
        match_q <= match_d;
        stable_q <= stable_d;
        axis_q <= 1'b0;
      end else if (state_q == ST_DIV && cnt_q == '0) begin
        axis_q <= 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      samp_x_q <= s_axis_tdata[SW_-1:0];
      samp_y_q <= s_axis_tdata[2*SW_-1:SW_];
      ok_q <= s_axis_tuser[0];
      down_q <= stable_d;
      pressed_q <= stable_d && !stable_q;
    end
    if (state_q == ST_PREP) begin
      neg_q <= !(value > 0);
      if (zero_axis) begin
        mag_q <= '0;
        div_q <= FullW'(1);
      end else begin
        mag_q <= mag_c[SW_-1:0];
        div_q <= span[FullW-1:0];
      end
    end
    if (state_q == ST_MUL) begin
      rem_q <= FullW'(prod[ProdW-1:AW_]);
      quo_q <= prod[AW_-1:0];
      cnt_q <= CntW'(AW_ - 1);
    end
    if (state_q == ST_DIV) begin
      rem_q <= ge ? diff[FullW-1:0] : trial[FullW-1:0];
      quo_q <= {quo_q[AW_-2:0], ge};
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        if (axis_q) begin
          y_res_q <= res;
        end else begin
          x_res_q <= res;
        end
      end
    end
    if (load_out) begin
      out_data_q <= {6'b0, pressed_q, down_q, y_res_q, x_res_q};
    end
  end

endmodule

### tb/joystick_result_checker.sv
// Scoreboard for the joystick axis deadzone and debounce unit: watches the sample,
// reading and register-write channels, predicts each reading and compares it.
// Depends on jadd_pkg.
`timescale 1ns / 100ps

module joystick_result_checker
  import jadd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  // sample_x [11:0], sample_y [23:12], button_pin [24], zero padding
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,
  // sample_ok [0]
  input  logic [S_TUSER_W-1:0]  s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // x_out [15:0], y_out [31:16], btn_held [32], btn_rise [33], zero padding
  input  logic [M_TDATA_W-1:0]  m_axis_tdata,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    mismatch_cnt_o,
  output int                    outstanding_o
);

  localparam int ADC_FULL = (1 << ADC_WIDTH_DEFAULT) - 1;
  localparam int SHOWN_MISMATCHES = 10;

  typedef struct packed {
    logic [OUT_W-1:0] x;
    logic [OUT_W-1:0] y;
    logic             down;
    logic             pressed;
  } joy_reading_t;

  logic [CENTER_W-1:0]   center_x_r;
  logic [CENTER_W-1:0]   center_y_r;
  logic [DEADZONE_W-1:0] deadzone_r;
  logic [AXIS_W-1:0]     axis_max_r;
  logic [DEBOUNCE_W-1:0] debounce_r;

  logic                  last_level_r;
  logic [DEBOUNCE_W-1:0] match_cnt_r;
  logic                  stable_r;

  joy_reading_t awaited_readings[$];
  joy_reading_t want;
  joy_reading_t got;
  int           mismatches;

  function automatic logic [OUT_W-1:0] scale_deflection(input int raw, input int ctr);
    int     dz;
    int     offset;
    int     span;
    int     mag;
    longint scaled;
    dz = int'(deadzone_r);
    offset = raw - ctr;
    if (offset > -dz && offset < dz) return '0;
    if (offset > 0) begin
      span = ADC_FULL - ctr - dz;
      mag = offset - dz;
    end else begin
      span = ctr - dz;
      mag = -offset - dz;
    end
    if (span <= 0) return '0;
    if (mag > span) mag = span;
    scaled = (longint'(mag) * longint'(axis_max_r)) / longint'(span);
    if (scaled > longint'(axis_max_r)) scaled = longint'(axis_max_r);
    return (offset > 0) ? OUT_W'(scaled) : OUT_W'(-scaled);
  endfunction

  function automatic joy_reading_t predict_reading(input logic [S_TDATA_W-1:0] data,
                                                   input logic [S_TUSER_W-1:0] user);
    joy_reading_t r;
    logic         pressed_raw;
    logic         held_before;
    r = '0;
    if (user[0]) begin
      r.x = scale_deflection(int'(data[11:0]), int'(center_x_r));
      r.y = scale_deflection(int'(data[23:12]), int'(center_y_r));
    end
    pressed_raw = ~data[24];
    if (pressed_raw == last_level_r) begin
      if (match_cnt_r < debounce_r) match_cnt_r = match_cnt_r + 1'b1;
    end else begin
      last_level_r = pressed_raw;
      match_cnt_r = DEBOUNCE_W'(1);
    end
    held_before = stable_r;
    if (match_cnt_r >= debounce_r) stable_r = last_level_r;
    r.down = stable_r;
    r.pressed = stable_r & ~held_before;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_r = CENTER_RESET;
      center_y_r = CENTER_RESET;
      deadzone_r = DEADZONE_RESET;
      axis_max_r = AXIS_MAX_RESET;
      debounce_r = DEBOUNCE_RESET;
      last_level_r = 1'b0;
      match_cnt_r = '0;
      stable_r = 1'b0;
      awaited_readings.delete();
      mismatches = 0;
      mismatch_cnt_o <= 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_CENTER_X:       center_x_r = cfg_data_i[CENTER_W-1:0];
          REG_CENTER_Y:       center_y_r = cfg_data_i[CENTER_W-1:0];
          REG_DEADZONE:       deadzone_r = cfg_data_i[DEADZONE_W-1:0];
          REG_AXIS_MAX:       axis_max_r = cfg_data_i[AXIS_W-1:0];
          REG_DEBOUNCE_COUNT: debounce_r = cfg_data_i[DEBOUNCE_W-1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.x = m_axis_tdata[15:0];
        got.y = m_axis_tdata[31:16];
        got.down = m_axis_tdata[32];
        got.pressed = m_axis_tdata[33];
        if (awaited_readings.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOWN_MISMATCHES)
            $display("%0t: unexpected reading x=%0d y=%0d down=%0b pressed=%0b", $realtime,
                     $signed(got.x), $signed(got.y), got.down, got.pressed);
        end else begin
          want = awaited_readings.pop_front();
          if (want.x != got.x || want.y != got.y || want.down != got.down ||
              want.pressed != got.pressed) begin
            mismatches++;
            if (mismatches <= SHOWN_MISMATCHES)
              $display("%0t: want x=%0d y=%0d dn=%0b pr=%0b, got x=%0d y=%0d dn=%0b pr=%0b",
                       $realtime, $signed(want.x), $signed(want.y), want.down, want.pressed,
                       $signed(got.x), $signed(got.y), got.down, got.pressed);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        awaited_readings.push_back(predict_reading(s_axis_tdata, s_axis_tuser));
      mismatch_cnt_o <= mismatches;
      outstanding_o <= awaited_readings.size();
    end
  end

endmodule

### tb/joystick_axis_deadzone_debounce_unit_tb.sv
// Testbench top for the joystick axis deadzone and debounce unit: drives samples and
// register writes, stalls the reading side and gives the verdict.
// Depends on jadd_pkg, joystick_result_checker and the unit itself.
`timescale 1ns / 100ps

module joystick_axis_deadzone_debounce_unit_tb;
  import jadd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASES = 9;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [S_TUSER_W-1:0]  s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  int                    mismatch_cnt;
  int                    outstanding;

  int cur_center_x = CENTER_RESET;
  int cur_center_y = CENTER_RESET;
  int cur_deadzone = DEADZONE_RESET;
  int cur_debounce = DEBOUNCE_RESET;
  logic pin_level = 1'b1;
  int pin_run_left = 0;
  int burst_left = 0;
  int rx_mode = 0;
  int rx_left = 0;
  int idle_cycles = 0;
  int phase_items;

  joystick_axis_deadzone_debounce_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  joystick_result_checker u_scoreboard (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_data_i     (cfg_data_i),
    .mismatch_cnt_o (mismatch_cnt),
    .outstanding_o  (outstanding)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(1, 40);
    end else begin
      rx_left = rx_left - 1;
    end
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      default: m_axis_tready <= 1'b0;
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_sample(input logic [11:0] sx, input logic [11:0] sy, input logic ok,
                             input logic pin);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, pin, sy, sx};
    s_axis_tuser <= ok;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_paced(input logic [11:0] sx, input logic [11:0] sy, input logic ok,
                            input logic pin);
    int gap;
    send_sample(sx, sy, ok, pin);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200) : $urandom_range(0, 12);
    end
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input int data);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= addr;
    cfg_data_i <= CFG_DATA_W'(data);
    @(posedge clk_i);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic configure(input int cx, input int cy, input int dz, input int amax,
                           input int deb);
    settle();
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_DEADZONE, dz);
    write_reg(REG_AXIS_MAX, amax);
    write_reg(REG_DEBOUNCE_COUNT, deb);
    cfg_we_i <= 1'b0;
    cur_center_x = cx & 12'hFFF;
    cur_center_y = cy & 12'hFFF;
    cur_deadzone = dz & 12'hFFF;
    cur_debounce = deb & 8'hFF;
  endtask

  function automatic logic [11:0] pick_sample(input int ctr);
    int v;
    int reach;
    reach = cur_deadzone + 64;
    case ($urandom_range(0, 9))
      0, 1, 2: v = $urandom_range(0, 4095);
      3: v = ($urandom_range(0, 1) != 0) ? 4095 : 0;
      4, 5: begin
        v = cur_deadzone + int'($urandom_range(0, 4)) - 2;
        v = ($urandom_range(0, 1) != 0) ? ctr + v : ctr - v;
      end
      default: v = ctr + int'($urandom_range(0, 2 * reach)) - reach;
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return 12'(v);
  endfunction

  function automatic logic next_pin();
    int deb;
    if (pin_run_left == 0) begin
      pin_level = ~pin_level;
      deb = (cur_debounce == 0) ? 1 : cur_debounce;
      case ($urandom_range(0, 4))
        0, 1: pin_run_left = $urandom_range(1, 3);
        2: pin_run_left = $urandom_range((deb > 1) ? deb - 1 : 1, deb + 1);
        default: pin_run_left = $urandom_range(deb, deb + 6);
      endcase
    end
    pin_run_left--;
    return pin_level;
  endfunction

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_sample(12'd2048, 12'd2048, 1'b1, 1'b1);
    send_sample(12'd0, 12'd4095, 1'b1, 1'b0);
    send_sample(12'd4095, 12'd0, 1'b1, 1'b0);
    send_sample(12'd2248, 12'd1848, 1'b1, 1'b1);
    send_sample(12'd2247, 12'd1849, 1'b1, 1'b0);
    send_sample(12'd2249, 12'd1847, 1'b1, 1'b0);
    send_sample(12'd0, 12'd4095, 1'b0, 1'b0);
    send_sample(12'd4095, 12'd4095, 1'b0, 1'b1);
    send_sample(12'd3048, 12'd1048, 1'b1, 1'b1);
    send_sample(12'd0, 12'd0, 1'b1, 1'b1);
    send_sample(12'd4095, 12'd4095, 1'b1, 1'b0);
    send_sample(12'd1, 12'd4094, 1'b1, 1'b0);
    send_sample(12'd2047, 12'd2049, 1'b1, 1'b1);

    for (int phase = 0; phase < PHASES; phase++) begin
      phase_items = 150;
      case (phase)
        0: phase_items = 250;
        1: configure(0, 4095, 0, 32767, 1);
        2: configure(4095, 0, 4095, 1, 0);
        3: configure(2048, 2047, 1, 0, 3);
        4: begin
          configure($urandom_range(1024, 3072), $urandom_range(1024, 3072),
                    $urandom_range(0, 300), $urandom_range(1, 32767), 255);
          phase_items = 550;
        end
        default: configure($urandom_range(0, 32767), $urandom_range(0, 32767),
                           $urandom_range(0, 600), $urandom_range(1, 32767),
                           $urandom_range(1, 12));
      endcase
      for (int n = 0; n < phase_items; n++)
        send_paced(pick_sample(cur_center_x), pick_sample(cur_center_y),
                   1'($urandom_range(0, 7) != 0), next_pin());
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/jadd_pkg.sv
rtl/joystick_axis_deadzone_debounce_unit.sv
tb/joystick_result_checker.sv
tb/joystick_axis_deadzone_debounce_unit_tb.sv
